[rtl/btb_pkg.sv]
// Shared types and constants for the two-level branch target buffer.
// Used by btb_cfg, the top level and the testbench; depends on nothing else.

package btb_pkg;

	// Fixed field widths
	localparam int PC_W  = 32;
	localparam int TAG_W = 30;
	localparam int CNT_W = 32;

	// Stream payload widths (whole bytes)
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 104;

	// Config port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	// Parameter defaults for the top level
	localparam int MAX_LINES_DEF   = 32;
	localparam int MAX_HISTORY_DEF = 8;

	// Largest line count exponent and reset values of the registers
	localparam logic [2:0] ENTRIES_LOG2_LIMIT = 3'd5;
	localparam logic [2:0] RST_ENTRIES_LOG2   = 3'd5;
	localparam logic [3:0] RST_HISTORY_BITS   = 4'd2;
	localparam logic [4:0] RST_TAG_BITS       = 5'd0;
	localparam logic [4:0] TAG_BITS_LIMIT     = 5'd30;

	// PC bit where the gshare variant takes its XOR bits
	localparam int SHARE_HI_LSB = 16;
	localparam int SHARE_LO_LSB = 2;

	// Two-bit saturating counter states
	localparam logic [1:0] CTR_SNT = 2'd0;
	localparam logic [1:0] CTR_WNT = 2'd1;
	localparam logic [1:0] CTR_WT  = 2'd2;
	localparam logic [1:0] CTR_ST  = 2'd3;

	// Request kinds
	typedef enum logic {
		CMD_PREDICT = 1'b0,
		CMD_UPDATE  = 1'b1
	} cmd_t;

	// Shared table index modes
	typedef enum logic [1:0] {
		SHARE_HIST = 2'd0,
		SHARE_PC2  = 2'd1,
		SHARE_PC16 = 2'd2
	} share_mode_t;

	// Register indexes of the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENTRIES_LOG2   = 3'd0,
		CFG_HISTORY_BITS   = 3'd1,
		CFG_TAG_BITS       = 3'd2,
		CFG_FSM_INIT       = 3'd3,
		CFG_GLOBAL_HISTORY = 3'd4,
		CFG_GLOBAL_TABLE   = 3'd5,
		CFG_SHARE_MODE     = 3'd6
	} cfg_index_t;

	// Clamped register contents
	typedef struct packed {
		logic [2:0]  entries_log2;
		logic [3:0]  history_bits;
		logic [4:0]  tag_bits;
		logic [1:0]  fsm_init;
		logic        global_history;
		logic        global_table;
		share_mode_t share_mode;
	} cfg_t;

endpackage

[rtl/btb_two_level_branch_predictor.sv]
// Top level of the two-level branch target buffer with gshare/lshare options.
// Uses btb_pkg, btb_cfg and btb_ram (line records and counter rows).
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+---------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata, tuser (command)
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata (prediction, counts)
//  cfg      | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// The accept edge issues the reads of the line memory and the counter-row memory;
// when stage 1 completes, which waits while the output register holds a result not
// yet taken, it compares, trains, writes back and loads the output register.
// A result waiting in the output register does not block acceptance by itself, but
// a new request is taken only once stage 1 is empty, so input stalls meanwhile.
// arst_n clears control, valid bits and statistics; no clearing pass is run.

module btb_two_level_branch_predictor #(
	parameter int MAX_LINES   = btb_pkg::MAX_LINES_DEF,
	parameter int MAX_HISTORY = btb_pkg::MAX_HISTORY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [31:0] pc, [63:32] target_pc, [64] taken, [96:65] pred_dst, rest zero
	input  logic [btb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] command
	input  logic [0:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [0] predict_taken, [32:1] predicted_target, [64:33] branch_count,
	// [96:65] flush_count, rest zero
	output logic [btb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [btb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [btb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int PC_W   = btb_pkg::PC_W;
	localparam int TAG_W  = btb_pkg::TAG_W;
	localparam int CNT_W  = btb_pkg::CNT_W;
	localparam int LINE_AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int ROW_AW  = $clog2(MAX_LINES + 1);
	localparam int ROWS    = MAX_LINES + 1;
	localparam int HIST_W  = MAX_HISTORY;
	localparam int ROW_N   = 1 << MAX_HISTORY;
	localparam int ROW_W   = 2 * ROW_N;
	localparam int REC_W   = TAG_W + PC_W;
	localparam logic [ROW_AW-1:0] SHARED_ROW = ROW_AW'(MAX_LINES);

	// Config
	btb_pkg::cfg_t cfg;
	logic          cfg_clear;

	btb_cfg #(
		.MAX_LINES   (MAX_LINES),
		.MAX_HISTORY (MAX_HISTORY)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.clear    (cfg_clear)
	);

	assign cfg_ready = 1'b1;

	// Input fields
	logic [PC_W-1:0] in_pc;
	logic [PC_W-1:0] in_target;
	logic            in_taken;
	logic [PC_W-1:0] in_pred_dst;
	logic            in_accept;

	assign in_pc       = s_axis_tdata[31:0];
	assign in_target   = s_axis_tdata[63:32];
	assign in_taken    = s_axis_tdata[64];
	assign in_pred_dst = s_axis_tdata[96:65];
	assign in_accept   = s_axis_tvalid && s_axis_tready;

	// Stage 1 registers and control state
	logic                valid_s1;
	btb_pkg::cmd_t       cmd_s1;
	logic [PC_W-1:0]     pc_s1;
	logic [PC_W-1:0]     target_s1;
	logic                taken_s1;
	logic [PC_W-1:0]     pred_dst_s1;
	logic [LINE_AW-1:0]  line_s1;
	logic [MAX_LINES-1:0] line_valid_q;
	logic                shared_row_valid_q;
	logic [HIST_W-1:0]   shared_hist_q;
	logic [HIST_W-1:0]   line_hist_q [MAX_LINES];
	logic [CNT_W-1:0]    updates_q;
	logic [CNT_W-1:0]    flushes_q;

	// Output register
	logic                out_valid_q;
	logic                out_taken_q;
	logic [PC_W-1:0]     out_target_q;
	logic [CNT_W-1:0]    out_branches_q;
	logic [CNT_W-1:0]    out_flushes_q;

	logic s1_done;
	assign s1_done       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1;

	// Read addresses at accept
	logic [LINE_AW-1:0] line_mask;
	logic [LINE_AW-1:0] line_s0;
	logic [ROW_AW-1:0]  row_rd_addr;

	assign line_mask   = LINE_AW'((32'd1 << cfg.entries_log2) - 32'd1);
	assign line_s0     = in_pc[2 +: LINE_AW] & line_mask;
	assign row_rd_addr = cfg.global_table ? SHARED_ROW : ROW_AW'(line_s0);

	// Memories
	logic [REC_W-1:0]  rec_rd;
	logic              rec_we;
	logic [REC_W-1:0]  rec_wr;
	logic [ROW_W-1:0]  row_rd;
	logic              row_we;
	logic [ROW_AW-1:0] row_wr_addr;
	logic [ROW_W-1:0]  row_new;

	btb_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_LINES),
		.AW    (LINE_AW)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (in_accept),
		.rd_addr (line_s0),
		.rd_data (rec_rd),
		.wr_en   (rec_we),
		.wr_addr (line_s1),
		.wr_data (rec_wr)
	);

	btb_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS),
		.AW    (ROW_AW)
	) u_ctr_ram (
		.clk     (clk),
		.rd_en   (in_accept),
		.rd_addr (row_rd_addr),
		.rd_data (row_rd),
		.wr_en   (row_we),
		.wr_addr (row_wr_addr),
		.wr_data (row_new)
	);

	// Stage 1: lookup, prediction and training
	logic [TAG_W-1:0]  rd_tag;
	logic [PC_W-1:0]   rd_target;
	logic [4:0]        tag_len;
	logic [TAG_W-1:0]  tag_mask;
	logic [TAG_W-1:0]  tag_val;
	logic              hit;
	logic [HIST_W-1:0] hmask;
	logic [HIST_W-1:0] hist_cur;
	logic [HIST_W-1:0] hist_new;
	logic [HIST_W-1:0] share_bits;
	logic [HIST_W-1:0] ctr_idx;
	logic [ROW_W-1:0]  init_row;
	logic [ROW_W-1:0]  row_base;
	logic [1:0]        ctr_cur;
	logic [1:0]        ctr_new;
	logic [PC_W-1:0]   pc_plus4;
	logic [PC_W-1:0]   real_dst;
	logic              is_update;
	logic              flush;
	logic              pred_taken;
	logic [PC_W-1:0]   pred_target;

	always_comb begin
		rd_tag    = rec_rd[TAG_W-1:0];
		rd_target = rec_rd[TAG_W +: PC_W];

		// Tag compare
		tag_len = (cfg.tag_bits > btb_pkg::TAG_BITS_LIMIT - 5'(cfg.entries_log2)) ?
			btb_pkg::TAG_BITS_LIMIT - 5'(cfg.entries_log2) : cfg.tag_bits;
		tag_mask = TAG_W'((31'd1 << tag_len) - 31'd1);
		tag_val  = TAG_W'(pc_s1 >> (6'd2 + 6'(cfg.entries_log2))) & tag_mask;
		hit      = line_valid_q[line_s1] && (rd_tag == tag_val);

		// History; a per-line history of a missing line counts as cleared
		hmask = HIST_W'(({{HIST_W{1'b0}}, 1'b1} << cfg.history_bits) - 1'b1);
		if (cfg.global_history) begin
			hist_cur = shared_hist_q & hmask;
		end else if (hit) begin
			hist_cur = line_hist_q[line_s1] & hmask;
		end else begin
			hist_cur = '0;
		end

		// Counter index
		share_bits = '0;
		if (cfg.global_table) begin
			unique case (cfg.share_mode)
				btb_pkg::SHARE_PC2:  share_bits = pc_s1[btb_pkg::SHARE_LO_LSB +: HIST_W];
				btb_pkg::SHARE_PC16: share_bits = pc_s1[btb_pkg::SHARE_HI_LSB +: HIST_W];
				default:             share_bits = '0;
			endcase
		end
		ctr_idx = (hist_cur ^ share_bits) & hmask;

		// Counter row as it stands; fresh rows read as the initial state
		init_row = {ROW_N{cfg.fsm_init}};
		if (cfg.global_table) begin
			row_base = shared_row_valid_q ? row_rd : init_row;
		end else begin
			row_base = hit ? row_rd : init_row;
		end
		ctr_cur = row_base[{ctr_idx, 1'b0} +: 2];

		// Saturating train
		if (taken_s1) begin
			ctr_new = (ctr_cur == btb_pkg::CTR_ST) ? btb_pkg::CTR_ST : ctr_cur + 2'd1;
		end else begin
			ctr_new = (ctr_cur == btb_pkg::CTR_SNT) ? btb_pkg::CTR_SNT : ctr_cur - 2'd1;
		end
		row_new = row_base;
		row_new[{ctr_idx, 1'b0} +: 2] = ctr_new;

		// Shifted history; from a cleared history this is just the taken bit
		hist_new = ((hist_cur << 1) | HIST_W'(taken_s1)) & hmask;

		// Prediction and flush check
		pc_plus4   = pc_s1 + 32'd4;
		real_dst   = taken_s1 ? target_s1 : pc_plus4;
		is_update  = (cmd_s1 == btb_pkg::CMD_UPDATE);
		flush      = (real_dst != pred_dst_s1);
		pred_taken = hit && (ctr_cur > btb_pkg::CTR_WNT);
		pred_target = pred_taken ? rd_target : pc_plus4;
	end

	// Write-back controls
	assign rec_we      = s1_done && is_update;
	assign rec_wr      = {target_s1, tag_val};
	assign row_we      = s1_done && is_update;
	assign row_wr_addr = cfg.global_table ? SHARED_ROW : ROW_AW'(line_s1);

	// Stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1      <= btb_pkg::cmd_t'(s_axis_tuser[0]);
			pc_s1       <= in_pc;
			target_s1   <= in_target;
			taken_s1    <= in_taken;
			pred_dst_s1 <= in_pred_dst;
			line_s1     <= line_s0;
		end
	end

	// Line valid bits, shared row validity, shared history, statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q       <= '0;
			shared_row_valid_q <= 1'b0;
			shared_hist_q      <= '0;
			updates_q          <= '0;
			flushes_q          <= '0;
		end else begin
			if (cfg_clear) begin
				line_valid_q       <= '0;
				shared_row_valid_q <= 1'b0;
				shared_hist_q      <= '0;
			end else if (s1_done && is_update) begin
				line_valid_q[line_s1] <= 1'b1;
				if (cfg.global_table) begin
					shared_row_valid_q <= 1'b1;
				end
				if (cfg.global_history) begin
					shared_hist_q <= hist_new;
				end
			end
			if (s1_done && is_update) begin
				updates_q <= updates_q + 32'd1;
				if (flush) begin
					flushes_q <= flushes_q + 32'd1;
				end
			end
		end
	end

	// Per-line histories; a line is read only after its allocation wrote it
	always_ff @(posedge clk) begin
		if (s1_done && is_update && !cfg.global_history) begin
			line_hist_q[line_s1] <= hist_new;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			out_taken_q    <= is_update ? 1'b0 : pred_taken;
			out_target_q   <= is_update ? '0 : pred_target;
			out_branches_q <= updates_q + CNT_W'(is_update);
			out_flushes_q  <= flushes_q + CNT_W'(is_update && flush);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_flushes_q, out_branches_q, out_target_q, out_taken_q};

`ifndef SYNTH
	// An update bumps the branch count by exactly one
	a_update_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && cmd_s1 == btb_pkg::CMD_UPDATE)
		|=> (updates_q == $past(updates_q) + 32'd1))
		else $error("branch count did not advance on update");

	// The flush count only moves together with the branch count
	a_flush_with_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(flushes_q) |-> !$stable(updates_q))
		else $error("flush count moved without an update");

	// A trained line is valid afterwards unless a config rebuild intervened
	a_line_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && cmd_s1 == btb_pkg::CMD_UPDATE && !cfg_clear)
		|=> line_valid_q[$past(line_s1)])
		else $error("updated line not marked valid");

	// The working stage never holds a request while another is accepted
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (valid_s1 && !s_axis_tready))
		else $error("request accepted over a busy stage");
`endif

endmodule

[rtl/btb_cfg.sv]
// Config register file of the branch target buffer: clamps written values
// and flags the table rebuild that every legal write causes. Uses btb_pkg.

module btb_cfg #(
	parameter int MAX_LINES   = btb_pkg::MAX_LINES_DEF,
	parameter int MAX_HISTORY = btb_pkg::MAX_HISTORY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [btb_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [btb_pkg::CFG_DATA_W-1:0] wr_data,
	output btb_pkg::cfg_t                 cfg,
	output logic                          clear
);

	// Largest exponent with 2^n lines still inside MAX_LINES
	localparam int EL2_MAX = $clog2(MAX_LINES + 1) - 1;
	localparam logic [2:0] EL2_CAP = (EL2_MAX < 5) ? 3'(EL2_MAX) : 3'd5;
	localparam logic [3:0] HIST_CAP = 4'(MAX_HISTORY);
	localparam logic [2:0] EL2_RST =
		(btb_pkg::RST_ENTRIES_LOG2 > EL2_CAP) ? EL2_CAP : btb_pkg::RST_ENTRIES_LOG2;
	localparam logic [3:0] HIST_RST =
		(btb_pkg::RST_HISTORY_BITS > HIST_CAP) ? HIST_CAP : btb_pkg::RST_HISTORY_BITS;

	btb_pkg::cfg_t cfg_q;
	btb_pkg::cfg_t cfg_next;
	logic          legal;
	logic [2:0]    el2_v;
	logic [3:0]    hist_v;

	// Clamp the written value into the selected register
	always_comb begin
		cfg_next = cfg_q;
		legal    = 1'b1;
		el2_v    = wr_data[2:0];
		hist_v   = wr_data[3:0];
		if (el2_v > EL2_CAP) begin
			el2_v = EL2_CAP;
		end
		if (hist_v == 4'd0) begin
			hist_v = 4'd1;
		end else if (hist_v > HIST_CAP) begin
			hist_v = HIST_CAP;
		end
		unique case (btb_pkg::cfg_index_t'(wr_index))
			btb_pkg::CFG_ENTRIES_LOG2:   cfg_next.entries_log2 = el2_v;
			btb_pkg::CFG_HISTORY_BITS:   cfg_next.history_bits = hist_v;
			btb_pkg::CFG_TAG_BITS:       cfg_next.tag_bits = wr_data;
			btb_pkg::CFG_FSM_INIT:       cfg_next.fsm_init = wr_data[1:0];
			btb_pkg::CFG_GLOBAL_HISTORY: cfg_next.global_history = wr_data[0];
			btb_pkg::CFG_GLOBAL_TABLE:   cfg_next.global_table = wr_data[0];
			btb_pkg::CFG_SHARE_MODE: begin
				if (wr_data[1:0] == 2'd3) begin
					cfg_next.share_mode = btb_pkg::SHARE_PC16;
				end else begin
					cfg_next.share_mode = btb_pkg::share_mode_t'(wr_data[1:0]);
				end
			end
			default: legal = 1'b0;
		endcase
	end

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entries_log2   <= EL2_RST;
			cfg_q.history_bits   <= HIST_RST;
			cfg_q.tag_bits       <= btb_pkg::RST_TAG_BITS;
			cfg_q.fsm_init       <= btb_pkg::CTR_WNT;
			cfg_q.global_history <= 1'b0;
			cfg_q.global_table   <= 1'b0;
			cfg_q.share_mode     <= btb_pkg::SHARE_HIST;
		end else if (wr_en && legal) begin
			cfg_q <= cfg_next;
		end
	end

	assign cfg   = cfg_q;
	assign clear = wr_en && legal;

endmodule

[rtl/btb_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read
// data. Used for line records and counter rows.

module btb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[test/btb_two_level_branch_predictor_tb.sv]
`timescale 1ns / 1ps
// Testbench for btb_two_level_branch_predictor: streams predict and update requests,
// reprograms the config channel between phases and checks each result field by field
// against a behavioral copy of the buffer held in btb_outcome_board. Needs btb_pkg.

import btb_pkg::*;

localparam int ROW_LEN = 1 << MAX_HISTORY_DEF;

typedef struct {
	cmd_t        command;
	logic [31:0] pc;
	logic [31:0] target_pc;
	logic        taken;
	logic [31:0] pred_dst;
} branch_req_t;

typedef struct {
	logic        predict_taken;
	logic [31:0] predicted_target;
	logic [31:0] branch_count;
	logic [31:0] flush_count;
} branch_res_t;

// Behavioral copy of the buffer plus the queue of outcomes still owed by the block
class btb_outcome_board;
	bit [2:0]    entries_log2;
	bit [3:0]    history_bits;
	bit [4:0]    tag_bits;
	bit [1:0]    ctr_init;
	bit          shared_hist_on;
	bit          shared_table_on;
	share_mode_t share_mode;

	bit          line_valid[MAX_LINES_DEF];
	bit [29:0]   line_tag[MAX_LINES_DEF];
	bit [31:0]   line_target[MAX_LINES_DEF];
	bit [7:0]    line_hist[MAX_LINES_DEF];
	bit [7:0]    shared_hist;
	bit [1:0]    line_ctr[MAX_LINES_DEF][ROW_LEN];
	bit [1:0]    shared_ctr[ROW_LEN];
	bit [31:0]   branches;
	bit [31:0]   flushes;

	branch_res_t awaited_results[$];
	int          mismatches;
	int          predicts;
	int          updates;
	int          taken_calls;

	function new();
		entries_log2    = RST_ENTRIES_LOG2;
		history_bits    = RST_HISTORY_BITS;
		tag_bits        = RST_TAG_BITS;
		ctr_init        = CTR_WNT;
		shared_hist_on  = 1'b0;
		shared_table_on = 1'b0;
		share_mode      = SHARE_HIST;
		branches        = '0;
		flushes         = '0;
		clear_tables();
	endfunction

	function void clear_tables();
		for (int i = 0; i < MAX_LINES_DEF; i++) begin
			line_valid[i]  = 1'b0;
			line_tag[i]    = '0;
			line_target[i] = '0;
			line_hist[i]   = '0;
			for (int j = 0; j < ROW_LEN; j++)
				line_ctr[i][j] = ctr_init;
		end
		for (int j = 0; j < ROW_LEN; j++)
			shared_ctr[j] = ctr_init;
		shared_hist = '0;
	endfunction

	// Register write to a mapped index: clamp, then rebuild all tables; statistics survive
	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_ENTRIES_LOG2:
				entries_log2 = (val[2:0] > ENTRIES_LOG2_LIMIT) ? ENTRIES_LOG2_LIMIT : val[2:0];
			CFG_HISTORY_BITS: begin
				history_bits = val[3:0];
				if (history_bits == 0) history_bits = 1;
				if (history_bits > MAX_HISTORY_DEF) history_bits = MAX_HISTORY_DEF;
			end
			CFG_TAG_BITS:       tag_bits = val;
			CFG_FSM_INIT:       ctr_init = val[1:0];
			CFG_GLOBAL_HISTORY: shared_hist_on = val[0];
			CFG_GLOBAL_TABLE:   shared_table_on = val[0];
			CFG_SHARE_MODE:
				share_mode = (val[1:0] > SHARE_PC16) ? SHARE_PC16 : share_mode_t'(val[1:0]);
			default: return;
		endcase
		clear_tables();
	endfunction

	function int unsigned hist_mask();
		return (32'd1 << history_bits) - 1;
	endfunction

	function int unsigned line_of(logic [31:0] pc);
		return (pc >> 2) & ((32'd1 << entries_log2) - 1);
	endfunction

	function int unsigned tag_of(logic [31:0] pc);
		int unsigned width;
		width = tag_bits;
		if (width > TAG_BITS_LIMIT - entries_log2) width = TAG_BITS_LIMIT - entries_log2;
		return (pc >> (2 + entries_log2)) & ((32'd1 << width) - 1);
	endfunction

	// History, optionally folded with pc bits when the table is shared
	function int unsigned ctr_index(logic [31:0] pc, int unsigned line);
		int unsigned h;
		h = (shared_hist_on ? shared_hist : line_hist[line]) & hist_mask();
		if (shared_table_on) begin
			if (share_mode == SHARE_PC2) h ^= (pc >> SHARE_LO_LSB) & hist_mask();
			else if (share_mode == SHARE_PC16) h ^= (pc >> SHARE_HI_LSB) & hist_mask();
		end
		return h & (ROW_LEN - 1);
	endfunction

	function bit [1:0] read_ctr(int unsigned line, int unsigned idx);
		return shared_table_on ? shared_ctr[idx] : line_ctr[line][idx];
	endfunction

	function void train_ctr(int unsigned line, int unsigned idx, bit up);
		bit [1:0] c;
		c = read_ctr(line, idx);
		if (up && c != CTR_ST) c = c + 2'd1;
		else if (!up && c != CTR_SNT) c = c - 2'd1;
		if (shared_table_on) shared_ctr[idx] = c;
		else line_ctr[line][idx] = c;
	endfunction

	// Accepted request: advance the copy and queue the outcome the block owes
	function branch_res_t predict_outcome(branch_req_t req);
		int unsigned line;
		int unsigned tag;
		bit          hit;
		logic [31:0] dest;
		branch_res_t res;
		line = line_of(req.pc);
		tag  = tag_of(req.pc);
		hit  = line_valid[line] && line_tag[line] == tag;
		res  = '{default: '0};
		if (req.command == CMD_PREDICT) begin
			predicts++;
			res.predicted_target = req.pc + 32'd4;
			if (hit && read_ctr(line, ctr_index(req.pc, line)) > CTR_WNT) begin
				res.predict_taken    = 1'b1;
				res.predicted_target = line_target[line];
				taken_calls++;
			end
		end else begin
			updates++;
			dest = req.taken ? req.target_pc : req.pc + 32'd4;
			branches++;
			if (dest != req.pred_dst) flushes++;
			if (!hit) begin
				// allocate: fresh local history and counter row
				line_tag[line]   = tag;
				line_valid[line] = 1'b1;
				if (!shared_hist_on) line_hist[line] = '0;
				if (!shared_table_on)
					for (int i = 0; i < (1 << history_bits); i++)
						line_ctr[line][i] = ctr_init;
			end
			line_target[line] = req.target_pc;
			train_ctr(line, ctr_index(req.pc, line), req.taken);
			if (shared_hist_on)
				shared_hist = ((shared_hist << 1) | req.taken) & hist_mask();
			else if (hit)
				line_hist[line] = ((line_hist[line] << 1) | req.taken) & hist_mask();
			else
				line_hist[line] = req.taken;
		end
		res.branch_count = branches;
		res.flush_count  = flushes;
		awaited_results.push_back(res);
		return res;
	endfunction

	function void flag(string what, logic [31:0] want, logic [31:0] got);
		if (mismatches < 40)
			$display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
		mismatches++;
	endfunction

	// Result from the master side against the oldest owed outcome
	function void check_outcome(logic [OUT_DATA_W-1:0] word);
		branch_res_t want;
		if (awaited_results.size() == 0) begin
			if (mismatches < 40)
				$display("%0t: result with nothing pending, expected none got %h",
					$time, word);
			mismatches++;
			return;
		end
		want = awaited_results.pop_front();
		if (word[0] !== want.predict_taken)
			flag("predict_taken", want.predict_taken, word[0]);
		if (word[32:1] !== want.predicted_target)
			flag("predicted_target", want.predicted_target, word[32:1]);
		if (word[64:33] !== want.branch_count)
			flag("branch_count", want.branch_count, word[64:33]);
		if (word[96:65] !== want.flush_count)
			flag("flush_count", want.flush_count, word[96:65]);
	endfunction
endclass

module btb_two_level_branch_predictor_tb;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int STALL_PCT       = 25;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RUN_LIMIT_NS    = 10_000_000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	btb_outcome_board board;
	branch_res_t      last_outcome;
	bit               steady = 1'b0;
	int               settings_used = 0;

	btb_two_level_branch_predictor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("tb: failure");
		$finish;
	end

	// Result side: check what was taken at this edge, then pick the next ready
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			board.check_outcome(m_axis_tdata);
		m_axis_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
	end

	// One request; returns at the edge that accepted it
	task automatic send(cmd_t command, logic [31:0] pc, logic [31:0] target_pc,
			logic taken, logic [31:0] pred_dst);
		branch_req_t req;
		req = '{command, pc, target_pc, taken, pred_dst};
		while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, pred_dst, taken, target_pc, pc};
		s_axis_tuser  <= command;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		last_outcome = board.predict_outcome(req);
	endtask

	// Stop the stream and wait until every owed result is back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (board.awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, val);
	endtask

	task automatic apply_settings(logic [4:0] e, logic [4:0] h, logic [4:0] t,
			logic [4:0] f, logic [4:0] gh, logic [4:0] gt, logic [4:0] sm,
			bit poke_unused);
		cfg_write(CFG_ENTRIES_LOG2, e);
		cfg_write(CFG_HISTORY_BITS, h);
		cfg_write(CFG_TAG_BITS, t);
		cfg_write(CFG_FSM_INIT, f);
		cfg_write(CFG_GLOBAL_HISTORY, gh);
		cfg_write(CFG_GLOBAL_TABLE, gt);
		cfg_write(CFG_SHARE_MODE, sm);
		// an unmapped index must leave the tables alone
		if (poke_unused) cfg_write(CFG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Mostly predict/update pairs over a small set of branches, some strays and noise
	task automatic run_phase(int unsigned n_items);
		logic [31:0] pool_pc[12];
		logic [31:0] pool_tgt[12];
		int unsigned pool_bias[12];
		int unsigned pool_n;
		int unsigned sent;
		int unsigned pick;
		int unsigned roll;
		logic [31:0] dst;
		pool_n = $urandom_range(1, 12);
		for (int k = 0; k < pool_n; k++) begin
			// some branches alias the first one on its line with another tag
			if (k > 0 && $urandom_range(0, 1))
				pool_pc[k] = pool_pc[0] ^ (32'd1 << $urandom_range(2, 31));
			else
				pool_pc[k] = $urandom;
			pool_tgt[k]  = $urandom;
			pool_bias[k] = $urandom_range(0, 100);
		end
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, pool_n - 1);
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				send(CMD_PREDICT, pool_pc[pick], $urandom, $urandom_range(0, 1), $urandom);
				dst = ($urandom_range(0, 9) == 0) ? $urandom : last_outcome.predicted_target;
				if ($urandom_range(0, 9) == 0) pool_tgt[pick] = $urandom;
				send(CMD_UPDATE, pool_pc[pick], pool_tgt[pick],
					$urandom_range(0, 99) < pool_bias[pick], dst);
				sent += 2;
			end else if (roll < 85) begin
				send(cmd_t'($urandom_range(0, 1)), pool_pc[pick], pool_tgt[pick],
					$urandom_range(0, 1), $urandom);
				sent++;
			end else begin
				send(cmd_t'($urandom_range(0, 1)), $urandom, $urandom,
					$urandom_range(0, 1), $urandom);
				sent++;
			end
		end
		settle();
	endtask

	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: empty buffer, pc+4 wrap, flush and no-flush updates
		send(CMD_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000);
		send(CMD_PREDICT, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send(CMD_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
		send(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send(CMD_UPDATE, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0, 32'h0000_0000);
		// drive the counters to strong taken, then back down
		for (int i = 0; i < 4; i++) begin
			send(CMD_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
			send(CMD_UPDATE, 32'hFFFF_FFFC, 32'h8000_0000, 1'b1,
				last_outcome.predicted_target);
		end
		for (int i = 0; i < 3; i++) begin
			send(CMD_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
			send(CMD_UPDATE, 32'hFFFF_FFFC, 32'h8000_0000, 1'b0,
				last_outcome.predicted_target);
		end
		send(CMD_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000);
		send(CMD_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000);
		settle();
		run_phase(ITEMS_PER_PHASE);

		// Extremes: single line with clamped widths, then widest tags and history
		apply_settings(5'd0, 5'd0, 5'd31, 5'd0, 5'd1, 5'd1, 5'd3, 1'b0);
		run_phase(ITEMS_PER_PHASE);
		apply_settings(5'd7, 5'd15, 5'd30, 5'd3, 5'd0, 5'd0, 5'd1, 1'b0);
		run_phase(ITEMS_PER_PHASE);

		// Long stretch with neither side idling
		apply_settings(5'd5, 5'd8, 5'd0, 5'd2, 5'd1, 5'd1, 5'd1, 1'b0);
		steady = 1'b1;
		run_phase(ITEMS_PER_PHASE);
		steady = 1'b0;

		apply_settings(5'd2, 5'd3, 5'd4, 5'd1, 5'd0, 5'd1, 5'd2, 1'b1);
		run_phase(ITEMS_PER_PHASE);

		// Random register contents, out-of-range values included
		for (int p = 0; p < 4; p++) begin
			apply_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom_range(0, 1));
			run_phase(ITEMS_PER_PHASE);
		end

		$display("run covered %0d predicts (%0d called taken) and %0d updates",
			board.predicts, board.taken_calls, board.updates);
		$display("over %0d register settings after reset, %0d mismatches",
			settings_used, board.mismatches);
		if (board.mismatches == 0 && board.awaited_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
